@@ rtl/dbpe_pkg.sv @@
`default_nettype none
package dbpe_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int ACC_W          = 40;
    localparam logic signed [31:0] FIX_ONE  = 32'sd65536;
    localparam logic signed [26:0] PROG_MIN = -27'sd131072;
    localparam logic signed [26:0] PROG_MAX = 27'sd131071;
    localparam logic signed [26:0] PROG_ONE = 27'sd65536;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef enum logic [1:0] {
        CFG_SPEED   = 2'd0,
        CFG_AUTO    = 2'd1,
        CFG_RETRACE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_STEP,
        S_PROG,
        S_PASCAL,
        S_POW,
        S_TERM_RD,
        S_PT,
        S_COEF,
        S_BIN,
        S_X,
        S_Y,
        S_Z
    } state_t;

    // Q16.16 product: floor shift by 16, saturate to 32 bits
    function automatic logic signed [31:0] fix_q16(input logic signed [63:0] p);
        logic signed [31:0] r;
        if (p[63:47] == {17{p[47]}})
            r = p[47:16];
        else
            r = p[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return r;
    endfunction

    function automatic logic signed [31:0] sat_p32(input logic signed [63:0] p);
        logic signed [31:0] r;
        if (p[63:31] == {33{p[31]}})
            r = p[31:0];
        else
            r = p[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return r;
    endfunction

    function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] a);
        logic signed [31:0] r;
        if (a[ACC_W-1:31] == {(ACC_W-31){a[31]}})
            r = a[31:0];
        else
            r = a[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/dolly_bezier_path_evaluator.sv @@
`default_nettype none
// Dolly path evaluator: holds up to MAX_POINTS 3-D control points and a
// progress value, and answers each input word with one result word.
// Input channel (in_valid/in_ready): action 0 inserts a point at
// insert_position (appends past the end, flags insert_dropped when full);
// action 1 is a tick that moves progress by speed*delta_time and returns
// the Bernstein-form Bezier point at the new progress.
// Output channel (out_valid/out_ready) is a register: a finished word
// waits there while the next input word is already taken in.
// Configuration: cfg_we/cfg_index/cfg_data write speed, auto_move and
// retrace_track; write only while idle.
// Arithmetic: every product goes through one shared bit-serial multiplier,
// so products are formed one after another. Items are worked one at a time.
// Reset clears points, progress, retrace state and the registers to their
// defaults (speed 1.0). When the receiver stalls, the finished word holds
// in the output register and the block waits before loading the next one.
module dolly_bezier_path_evaluator #(
    parameter int MAX_POINTS = dbpe_pkg::MAX_POINTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [23:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               action,
    input  wire logic [7:0]         insert_position,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    input  wire logic [15:0]        delta_time,
    input  wire logic               key_left,
    input  wire logic               key_right,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      eye_x,
    output logic signed [31:0]      eye_y,
    output logic signed [31:0]      eye_z,
    output logic signed [17:0]      progress_out,
    output logic                    going_back,
    output logic                    insert_dropped
);
    import dbpe_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_POINTS);

    state_t state_reg, state_next;

    // control
    logic [CNT_W-1:0]    cnt_reg;
    logic signed [17:0]  prog_reg;
    logic                retr_reg;
    logic [23:0]         speed_reg;
    logic                auto_reg;
    logic                retrace_reg;
    logic                wait_reg;
    logic                out_valid_reg;
    logic                mul_emit_now;
    logic                z_owed_reg;

    // payload
    logic                act_reg;
    logic [7:0]          pos_reg;
    point_t              pt_in_reg;
    logic [15:0]         dt_reg;
    logic                kl_reg;
    logic                kr_reg;
    logic [IDX_W-1:0]    k_reg;
    logic [IDX_W-1:0]    i_reg;
    logic [IDX_W-1:0]    j_reg;
    logic [IDX_W-1:0]    n_reg;
    logic [IDX_W-1:0]    pc_reg;
    logic [31:0]         row_reg [MAX_POINTS];
    logic [24:0]         step_reg;
    logic signed [31:0]  pu_reg;
    logic signed [31:0]  pt_reg;
    logic signed [31:0]  coef_reg;
    logic signed [31:0]  c_reg;
    logic signed [ACC_W-1:0] ax_reg, ay_reg, az_reg;
    logic                drop_reg;
    logic signed [31:0]  eye_x_reg, eye_y_reg, eye_z_reg;
    logic signed [17:0]  prog_out_reg;
    logic                back_reg;
    logic                dropped_reg;

    // multiplier
    logic                mul_start;
    logic signed [31:0]  mul_a, mul_b;
    logic                mul_done;
    logic signed [63:0]  mul_p;
    logic signed [31:0]  mul_fix;
    logic                mul_fin;

    // memories
    logic                st_we;
    logic [IDX_W-1:0]    st_waddr, st_raddr;
    point_t              st_wdata, st_rdata;
    logic                pw_we;
    logic [IDX_W-1:0]    pw_waddr, pw_raddr;
    logic signed [31:0]  pw_wdata, pw_rdata;

    // insert helpers
    logic [8:0]          pos_eff;
    logic                shift_more;
    logic                accept_in;
    logic                emit_go;

    // progress update
    logic signed [26:0]  p_cur, p_base, p_sum, p_new;
    logic                retr_new;
    logic signed [31:0]  u_val;

    assign accept_in = in_valid && in_ready;
    assign mul_fin   = mul_done && wait_reg;
    assign mul_fix   = fix_q16(mul_p);
    assign emit_go   = !out_valid_reg || out_ready;

    // emit happens in S_Z once no term multiply is owed
    assign mul_emit_now = !z_owed_reg;

    assign pos_eff    = ({1'b0, pos_reg} >= 9'(cnt_reg)) ? 9'(cnt_reg) : {1'b0, pos_reg};
    assign shift_more = 9'(k_reg) > pos_eff;
    assign u_val      = FIX_ONE - 32'(prog_reg);

    // ---------------- progress arithmetic ----------------
    always_comb
    begin
        p_cur    = 27'(prog_reg);
        p_base   = p_cur;
        retr_new = retr_reg;
        p_sum    = p_cur;
        p_new    = p_cur;
        if (auto_reg)
        begin
            if (p_cur >= PROG_ONE)
            begin
                if (retrace_reg)
                    retr_new = 1'b1;
                else
                    p_base = '0;
            end
            else if (p_cur <= 27'sd0)
            begin
                if (retrace_reg)
                    retr_new = 1'b0;
                else
                    p_base = '0;
            end
            p_sum = retr_new ? p_base - $signed({2'b00, step_reg})
                             : p_base + $signed({2'b00, step_reg});
            if (p_sum < PROG_MIN)
                p_new = PROG_MIN;
            else if (p_sum > PROG_MAX)
                p_new = PROG_MAX;
            else
                p_new = p_sum;
        end
        else
        begin
            if (kl_reg)
                p_sum = p_cur - $signed({2'b00, step_reg});
            else if (kr_reg)
                p_sum = p_cur + $signed({2'b00, step_reg});
            if (p_sum < 27'sd0)
                p_new = '0;
            else if (p_sum > PROG_ONE)
                p_new = PROG_ONE;
            else
                p_new = p_sum;
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = (action == ACT_TICK) ? S_STEP : S_INS;
            S_INS:
                if (cnt_reg == CNT_FULL)
                    state_next = S_Z;
                else if (shift_more)
                    state_next = S_INS_RD;
                else
                    state_next = S_INS_PUT;
            S_INS_RD:  state_next = S_INS_WR;
            S_INS_WR:  state_next = S_INS;
            S_INS_PUT: state_next = S_Z;
            S_STEP:
                if (mul_fin)
                    state_next = S_PROG;
            S_PROG:
                state_next = (cnt_reg == '0) ? S_Z : S_PASCAL;
            S_PASCAL:
                if (pc_reg == '0)
                    state_next = S_POW;
            S_POW:
                if (j_reg == n_reg)
                    state_next = S_TERM_RD;
            S_TERM_RD:
                state_next = (i_reg == '0) ? S_COEF : S_PT;
            S_PT:
                if (mul_fin)
                    state_next = S_COEF;
            S_COEF:
                if (mul_fin)
                    state_next = S_BIN;
            S_BIN:
                if (mul_fin)
                    state_next = S_X;
            S_X:
                if (mul_fin)
                    state_next = S_Y;
            S_Y:
                if (mul_fin)
                    state_next = S_Z;
            S_Z:
                // S_Z doubles as the emit point: its multiply runs only in a tick;
                // after the last term, stay here and emit once the output register is free
                if (wait_reg)
                begin
                    if (mul_done && (i_reg != n_reg))
                        state_next = S_TERM_RD;
                end
                else if (!((act_reg == ACT_TICK) && (cnt_reg != '0) && !mul_emit_now))
                begin
                    if (emit_go)
                        state_next = S_IDLE;
                end
            default:   state_next = S_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        st_we     = 1'b0;
        st_waddr  = k_reg;
        st_wdata  = st_rdata;
        st_raddr  = i_reg;
        pw_we     = 1'b0;
        pw_waddr  = j_reg;
        pw_wdata  = pu_reg;
        pw_raddr  = IDX_W'(n_reg - i_reg);
        in_ready  = (state_reg == S_IDLE);
        case (state_reg)
            S_INS_RD:
                st_raddr = IDX_W'(k_reg - IDX_W'(1));
            S_INS_WR:
            begin
                st_raddr = IDX_W'(k_reg - IDX_W'(1));
                st_we    = 1'b1;
            end
            S_INS_PUT:
            begin
                st_we    = 1'b1;
                st_waddr = IDX_W'(pos_eff);
                st_wdata = pt_in_reg;
            end
            S_STEP:
            begin
                mul_start = !wait_reg;
                mul_a     = {8'd0, speed_reg};
                mul_b     = {16'd0, dt_reg};
            end
            S_PROG:
            begin
                pw_we    = 1'b1;
                pw_waddr = '0;
                pw_wdata = FIX_ONE;
            end
            S_POW:
            begin
                mul_start = !wait_reg && (j_reg != n_reg);
                mul_a     = pu_reg;
                mul_b     = u_val;
                pw_we     = mul_fin;
                pw_waddr  = IDX_W'(j_reg + IDX_W'(1));
                pw_wdata  = mul_fix;
            end
            S_PT:
            begin
                mul_start = !wait_reg;
                mul_a     = pt_reg;
                mul_b     = 32'(prog_reg);
            end
            S_COEF:
            begin
                mul_start = !wait_reg;
                mul_a     = pw_rdata;
                mul_b     = pt_reg;
            end
            S_BIN:
            begin
                mul_start = !wait_reg;
                mul_a     = $signed(row_reg[0]);
                mul_b     = coef_reg;
            end
            S_X:
            begin
                mul_start = !wait_reg;
                mul_a     = c_reg;
                mul_b     = st_rdata.x;
            end
            S_Y:
            begin
                mul_start = !wait_reg;
                mul_a     = c_reg;
                mul_b     = st_rdata.y;
            end
            S_Z:
            begin
                mul_start = !wait_reg && z_owed_reg;
                mul_a     = c_reg;
                mul_b     = st_rdata.z;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            prog_reg      <= '0;
            retr_reg      <= 1'b0;
            speed_reg     <= 24'd65536;
            auto_reg      <= 1'b0;
            retrace_reg   <= 1'b0;
            wait_reg      <= 1'b0;
            z_owed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SPEED:   speed_reg   <= cfg_data;
                    CFG_AUTO:    auto_reg    <= cfg_data[0];
                    CFG_RETRACE: retrace_reg <= cfg_data[0];
                    default:     speed_reg   <= speed_reg;
                endcase
            end
            if (mul_start)
                wait_reg <= 1'b1;
            else if (mul_done)
                wait_reg <= 1'b0;
            if (state_reg == S_INS_PUT)
                cnt_reg <= CNT_W'(cnt_reg + CNT_W'(1));
            if (state_reg == S_PROG)
            begin
                prog_reg <= p_new[17:0];
                retr_reg <= retr_new;
            end
            if (state_reg == S_Y && mul_fin)
                z_owed_reg <= 1'b1;
            else if (state_reg == S_Z && mul_fin)
                z_owed_reg <= 1'b0;
            if (state_reg == S_Z && state_next == S_IDLE && !wait_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            act_reg   <= action;
            pos_reg   <= insert_position;
            pt_in_reg <= '{x: point_x, y: point_y, z: point_z};
            dt_reg    <= delta_time;
            kl_reg    <= key_left;
            kr_reg    <= key_right;
            k_reg     <= IDX_W'(cnt_reg);
            ax_reg    <= '0;
            ay_reg    <= '0;
            az_reg    <= '0;
            drop_reg  <= (action == ACT_INSERT) && (cnt_reg == CNT_FULL);
        end
        case (state_reg)
            S_INS_WR:
                k_reg <= IDX_W'(k_reg - IDX_W'(1));
            S_STEP:
                if (mul_fin)
                    step_reg <= mul_p[40:16];
            S_PROG:
            begin
                n_reg  <= IDX_W'(cnt_reg - CNT_W'(1));
                pc_reg <= IDX_W'(cnt_reg - CNT_W'(1));
                j_reg  <= '0;
                i_reg  <= '0;
                pu_reg <= FIX_ONE;
                pt_reg <= FIX_ONE;
                for (int r = 0; r < MAX_POINTS; r++)
                    row_reg[r] <= (r == 0) ? 32'd1 : 32'd0;
            end
            S_PASCAL:
                if (pc_reg != '0)
                begin
                    // one Pascal row per cycle, all lanes together
                    for (int r = 1; r < MAX_POINTS; r++)
                        row_reg[r] <= row_reg[r] + row_reg[r-1];
                    pc_reg <= IDX_W'(pc_reg - IDX_W'(1));
                end
            S_POW:
                if (mul_fin)
                begin
                    pu_reg <= mul_fix;
                    j_reg  <= IDX_W'(j_reg + IDX_W'(1));
                end
            S_PT:
                if (mul_fin)
                    pt_reg <= mul_fix;
            S_COEF:
                if (mul_fin)
                    coef_reg <= mul_fix;
            S_BIN:
                if (mul_fin)
                begin
                    c_reg <= sat_p32(mul_p);
                    // advance the binomial row to the next term
                    for (int r = 0; r < MAX_POINTS - 1; r++)
                        row_reg[r] <= row_reg[r+1];
                    row_reg[MAX_POINTS-1] <= '0;
                end
            S_X:
                if (mul_fin)
                    ax_reg <= ax_reg + ACC_W'(mul_fix);
            S_Y:
                if (mul_fin)
                    ay_reg <= ay_reg + ACC_W'(mul_fix);
            S_Z:
                if (mul_fin)
                begin
                    az_reg <= az_reg + ACC_W'(mul_fix);
                    if (i_reg != n_reg)
                        i_reg <= IDX_W'(i_reg + IDX_W'(1));
                end
            default:
                pc_reg <= pc_reg;
        endcase
        if (state_reg == S_Z && state_next == S_IDLE && !wait_reg)
        begin
            eye_x_reg    <= sat_acc(ax_reg);
            eye_y_reg    <= sat_acc(ay_reg);
            eye_z_reg    <= sat_acc(az_reg);
            prog_out_reg <= prog_reg;
            back_reg     <= retr_reg;
            dropped_reg  <= drop_reg;
        end
    end

    dbpe_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    dbpe_store #(
        .DEPTH (MAX_POINTS),
        .IDX_W (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    dbpe_pow #(
        .DEPTH (MAX_POINTS),
        .IDX_W (IDX_W)
    ) u_pow (
        .clk   (clk),
        .we    (pw_we),
        .waddr (pw_waddr),
        .wdata (pw_wdata),
        .raddr (pw_raddr),
        .rdata (pw_rdata)
    );

    assign out_valid      = out_valid_reg;
    assign eye_x          = eye_x_reg;
    assign eye_y          = eye_y_reg;
    assign eye_z          = eye_z_reg;
    assign progress_out   = prog_out_reg;
    assign going_back     = back_reg;
    assign insert_dropped = dropped_reg;
endmodule
`default_nettype wire

@@ rtl/dbpe_mul.sv @@
`default_nettype none
// Signed 32x32 multiply, one multiplier bit per cycle on magnitudes.
module dbpe_mul (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic                    done,
    output logic signed [63:0]      product
);
    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic        neg_reg;
    logic [31:0] ma_reg;
    logic [63:0] prod_reg;
    logic signed [63:0] product_reg;
    logic [32:0] sum;
    logic [31:0] mag_a;
    logic [31:0] mag_b;

    assign mag_a = a[31] ? 32'(-a) : a;
    assign mag_b = b[31] ? 32'(-b) : b;
    assign sum = {1'b0, prod_reg[63:32]} + (prod_reg[0] ? {1'b0, ma_reg} : 33'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                if (cnt_reg != 6'd0)
                    cnt_reg <= cnt_reg - 6'd1;
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg   <= mag_a;
            neg_reg  <= a[31] ^ b[31];
            prod_reg <= {32'd0, mag_b};
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 6'd0)
                prod_reg <= {sum, prod_reg[31:1]};
            else
                product_reg <= neg_reg ? -$signed(prod_reg) : $signed(prod_reg);
        end
    end

    assign done    = done_reg;
    assign product = product_reg;
endmodule
`default_nettype wire

@@ rtl/dbpe_store.sv @@
`default_nettype none
// Control point memory: one write port, one registered read port.
module dbpe_store #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [IDX_W-1:0]    waddr,
    input  wire dbpe_pkg::point_t    wdata,
    input  wire logic [IDX_W-1:0]    raddr,
    output dbpe_pkg::point_t         rdata
);
    import dbpe_pkg::*;

    point_t mem [DEPTH];
    point_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

@@ rtl/dbpe_top_note.sv @@
`default_nettype none
// Power table of (1 - t): written once per tick, read per term.
module dbpe_pow #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [IDX_W-1:0]    waddr,
    input  wire logic signed [31:0]  wdata,
    input  wire logic [IDX_W-1:0]    raddr,
    output logic signed [31:0]       rdata
);
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

@@ tb/tb_dolly_bezier_path_evaluator.sv @@
`default_nettype none
module tb_dolly_bezier_path_evaluator;
    import dbpe_pkg::*;

    localparam int NPTS      = MAX_POINTS_DEF;
    localparam int IDLE_PCT  = 18;
    // long enough for a full-store tick, with stalls on top
    localparam int STALL_MAX = 40000;

    typedef struct {
        logic               act;
        logic [7:0]         pos;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0]        dt;
        logic               kl;
        logic               kr;
    } path_word_t;

    typedef struct {
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
        logic [17:0]        prog;
        logic               back;
        logic               drop;
    } eye_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [23:0] cfg_data = 24'd0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               action = 1'b0;
    logic [7:0]         insert_position = 8'd0;
    logic signed [31:0] point_x = 32'sd0;
    logic signed [31:0] point_y = 32'sd0;
    logic signed [31:0] point_z = 32'sd0;
    logic [15:0]        delta_time = 16'd0;
    logic               key_left = 1'b0;
    logic               key_right = 1'b0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [17:0] progress_out;
    logic               going_back;
    logic               insert_dropped;

    dolly_bezier_path_evaluator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .insert_position(insert_position),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .delta_time(delta_time), .key_left(key_left), .key_right(key_right),
        .out_valid(out_valid), .out_ready(out_ready),
        .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
        .progress_out(progress_out), .going_back(going_back),
        .insert_dropped(insert_dropped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Words waiting to be sent and eye points still owed by the block.
    path_word_t pending_words[$];
    eye_word_t  eye_expected[$];
    path_word_t cur_word;

    int errors = 0;
    int n_inserts = 0;
    int n_ticks = 0;
    int n_dropped = 0;
    int n_back = 0;
    int in_idle = IDLE_PCT;
    int out_idle = IDLE_PCT;
    bit hold_sender = 1'b0;
    int plan_count = 0;
    int stall_cycles = 0;

    // Shadow of the path store, progress and registers.
    logic signed [31:0] path_x[NPTS];
    logic signed [31:0] path_y[NPTS];
    logic signed [31:0] path_z[NPTS];
    int                 path_count = 0;
    longint             path_prog = 0;
    logic               path_back = 1'b0;
    logic [23:0]        reg_speed = 24'd65536;
    logic               reg_auto = 1'b0;
    logic               reg_retrace = 1'b0;

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Q16.16 multiply: floor after the shift, then saturate
    function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return clip32(p >>> 16);
    endfunction

    task automatic bezier_at(input logic signed [31:0] t, output eye_word_t r);
        longint row[NPTS];
        longint ax, ay, az;
        logic signed [31:0] u, pu, pt, c;
        int n;
        ax = 0;
        ay = 0;
        az = 0;
        r.ex = 0;
        r.ey = 0;
        r.ez = 0;
        if (path_count == 0)
            return;
        n = path_count - 1;
        u = 32'sd65536 - t;
        row[0] = 1;
        for (int i = 1; i <= n; i++)
        begin
            row[i] = 1;
            for (int j = i - 1; j > 0; j--)
                row[j] = row[j] + row[j - 1];
        end
        for (int i = 0; i <= n; i++)
        begin
            pu = 32'sd65536;
            pt = 32'sd65536;
            for (int j = 0; j < n - i; j++)
                pu = qmul(pu, u);
            for (int j = 0; j < i; j++)
                pt = qmul(pt, t);
            c = clip32(row[i] * longint'(qmul(pu, pt)));
            ax += qmul(c, path_x[i]);
            ay += qmul(c, path_y[i]);
            az += qmul(c, path_z[i]);
        end
        r.ex = clip32(ax);
        r.ey = clip32(ay);
        r.ez = clip32(az);
    endtask

    // Apply one accepted word to the shadow state and queue its eye point.
    task automatic advance_path(input path_word_t w);
        eye_word_t r;
        int p;
        longint step;
        r.ex = 0;
        r.ey = 0;
        r.ez = 0;
        r.drop = 1'b0;
        if (w.act == ACT_INSERT)
        begin
            n_inserts++;
            if (path_count >= NPTS)
            begin
                r.drop = 1'b1;
                n_dropped++;
            end
            else
            begin
                p = (w.pos > path_count) ? path_count : int'(w.pos);
                for (int k = path_count; k > p; k--)
                begin
                    path_x[k] = path_x[k - 1];
                    path_y[k] = path_y[k - 1];
                    path_z[k] = path_z[k - 1];
                end
                path_x[p] = w.x;
                path_y[p] = w.y;
                path_z[p] = w.z;
                path_count++;
            end
        end
        else
        begin
            n_ticks++;
            step = (longint'(reg_speed) * longint'(w.dt)) >> 16;
            if (reg_auto)
            begin
                // ends are judged before the step is applied
                if (path_prog >= 65536)
                begin
                    if (reg_retrace)
                        path_back = 1'b1;
                    else
                        path_prog = 0;
                end
                else if (path_prog <= 0)
                begin
                    if (reg_retrace)
                        path_back = 1'b0;
                    else
                        path_prog = 0;
                end
                path_prog = path_back ? path_prog - step : path_prog + step;
                if (path_prog < -131072)
                    path_prog = -131072;
                if (path_prog > 131071)
                    path_prog = 131071;
            end
            else
            begin
                // left key wins over right
                if (w.kl)
                    path_prog -= step;
                else if (w.kr)
                    path_prog += step;
                if (path_prog < 0)
                    path_prog = 0;
                if (path_prog > 65536)
                    path_prog = 65536;
            end
            bezier_at(path_prog[31:0], r);
            if (path_back)
                n_back++;
        end
        r.prog = path_prog[17:0];
        r.back = path_back;
        eye_expected = {eye_expected, r};
    endtask

    // Driver: advance to the next word once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                advance_path(cur_word);
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() > 0 && !hold_sender
                    && $urandom_range(99) >= in_idle)
                begin
                    cur_word = pending_words.pop_front();
                    action          <= cur_word.act;
                    insert_position <= cur_word.pos;
                    point_x         <= cur_word.x;
                    point_y         <= cur_word.y;
                    point_z         <= cur_word.z;
                    delta_time      <= cur_word.dt;
                    key_left        <= cur_word.kl;
                    key_right       <= cur_word.kr;
                    in_valid        <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // Monitor: check each eye word against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        eye_word_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (eye_expected.size() == 0)
                begin
                    report("unexpected word", 1, 0);
                end
                else
                begin
                    e = eye_expected.pop_front();
                    if (eye_x !== e.ex)
                        report("eye_x", eye_x, e.ex);
                    if (eye_y !== e.ey)
                        report("eye_y", eye_y, e.ey);
                    if (eye_z !== e.ez)
                        report("eye_z", eye_z, e.ez);
                    if (progress_out !== e.prog)
                        report("progress_out", progress_out, $signed(e.prog));
                    if (going_back !== e.back)
                        report("going_back", going_back, e.back);
                    if (insert_dropped !== e.drop)
                        report("insert_dropped", insert_dropped, e.drop);
                end
            end
            out_ready <= ($urandom_range(99) >= out_idle);
        end
    end

    // Watchdog: cycles with no word moving on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic put_word(input logic act, input logic [7:0] pos,
                            input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z, input logic [15:0] dt,
                            input logic kl, input logic kr);
        path_word_t w;
        w.act = act;
        w.pos = pos;
        w.x = x;
        w.y = y;
        w.z = z;
        w.dt = dt;
        w.kl = kl;
        w.kr = kr;
        if (act == ACT_INSERT)
            plan_count++;
        pending_words = {pending_words, w};
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(7))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2, 3: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
            default: return $urandom;
        endcase
    endfunction

    // Inserts stop at cap unless cap >= NPTS, keeping the store small so ticks stay short.
    task automatic put_random(input int count, input int cap, input int ins_pct);
        logic [15:0] dt;
        for (int i = 0; i < count; i++)
        begin
            if (plan_count < cap && $urandom_range(99) < ins_pct || cap >= NPTS
                && $urandom_range(99) < ins_pct)
            begin
                put_word(ACT_INSERT, 8'($urandom_range(255)), rand_coord(), rand_coord(),
                         rand_coord(), 16'($urandom), 1'($urandom), 1'($urandom));
            end
            else
            begin
                case ($urandom_range(5))
                    0: dt = 16'hffff;
                    1: dt = 16'd0;
                    2, 3: dt = 16'($urandom_range(16'h2000));
                    default: dt = 16'($urandom);
                endcase
                put_word(ACT_TICK, 8'($urandom), $urandom, $urandom, $urandom, dt,
                         1'($urandom), 1'($urandom));
            end
        end
    endtask

    // Hold until every word is sent and every eye point has come back.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_words.size() > 0 || in_valid || eye_expected.size() > 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [23:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_SPEED:   reg_speed = val;
            CFG_AUTO:    reg_auto = val[0];
            CFG_RETRACE: reg_retrace = val[0];
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic [23:0] spd, input logic am, input logic rt);
        write_reg(CFG_SPEED, spd);
        write_reg(CFG_AUTO, {23'd0, am});
        write_reg(CFG_RETRACE, {23'd0, rt});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty store, three inserts, keys and clamping at reset settings.
        put_word(ACT_TICK, 8'd0, 0, 0, 0, 16'hffff, 1'b0, 1'b1);
        put_word(ACT_TICK, 8'd0, 0, 0, 0, 16'h4000, 1'b1, 1'b0);
        put_word(ACT_INSERT, 8'd0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 16'd0, 1'b0, 1'b0);
        put_word(ACT_INSERT, 8'd255, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 16'hffff, 1'b1, 1'b1);
        put_word(ACT_INSERT, 8'd1, 32'sh0001_0000, -32'sh0003_8000, 32'sd0,
                 16'd0, 1'b0, 1'b0);
        put_word(ACT_TICK, 8'd0, 0, 0, 0, 16'd0, 1'b0, 1'b1);
        put_word(ACT_TICK, 8'd0, 0, 0, 0, 16'h8000, 1'b1, 1'b1);
        put_word(ACT_TICK, 8'd0, 0, 0, 0, 16'h8000, 1'b0, 1'b0);
        put_word(ACT_TICK, 8'd0, 0, 0, 0, 16'hffff, 1'b0, 1'b1);
        put_word(ACT_TICK, 8'd0, 0, 0, 0, 16'hffff, 1'b0, 1'b1);
        put_word(ACT_TICK, 8'd0, 0, 0, 0, 16'hffff, 1'b1, 1'b0);
        drain();

        // Directed: fastest speed, retrace, progress saturation both ways, then no retrace.
        set_mode(24'hffffff, 1'b1, 1'b1);
        for (int i = 0; i < 6; i++)
            put_word(ACT_TICK, 8'd0, 0, 0, 0, 16'hffff, 1'b0, 1'b0);
        drain();
        set_mode(24'h008000, 1'b1, 1'b0);
        for (int i = 0; i < 5; i++)
            put_word(ACT_TICK, 8'd0, 0, 0, 0, 16'hc000, 1'b0, 1'b0);
        drain();

        // Random phases over several register settings, store kept small.
        set_mode(24'd0, 1'b1, 1'b1);
        put_random(90, 4, 25);
        drain();
        set_mode(24'h010000, 1'b0, 1'b1);
        put_random(100, 4, 25);
        // let part of the batch go, then hold the sender until all eye points are back
        while (pending_words.size() > 50)
            @(negedge clk);
        hold_sender = 1'b1;
        do
            @(negedge clk);
        while (in_valid || eye_expected.size() > 0);
        hold_sender = 1'b0;
        put_random(88, 5, 25);
        drain();
        set_mode(24'($urandom), 1'b1, 1'b0);
        put_random(100, 5, 20);
        drain();
        // quiet stretch: no idling on either side
        in_idle = 0;
        out_idle = 0;
        set_mode(24'h020000, 1'b1, 1'b1);
        put_random(110, 5, 20);
        drain();
        in_idle = IDLE_PCT;
        out_idle = IDLE_PCT;
        set_mode(24'hffffff, 1'b0, 1'b0);
        put_random(80, 5, 25);
        drain();
        // Fill the store and overflow it with a few full-size ticks.
        set_mode(24'h004000, 1'b1, 1'b1);
        put_random(60, NPTS, 75);
        drain();

        $display("covered %0d inserts (%0d dropped) and %0d ticks, %0d while retracing",
                 n_inserts, n_dropped, n_ticks, n_back);
        $display("final store holds %0d points, %0d mismatches", path_count, errors);
        if (errors == 0 && eye_expected.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
